>>> sv/grsc_pkg.sv
`default_nettype none
package grsc_pkg;

   typedef enum logic [1:0] {
      PH_SIGN  = 2'd0,
      PH_LOW   = 2'd1,
      PH_UNARY = 2'd2,
      PH_END   = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_BIT  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_PULL = 1'b1;

   localparam logic CSR_LOW_BITS  = 1'b0;
   localparam logic CSR_HIGH_BITS = 1'b1;

   localparam int BIT_POS_W = 15;
   localparam int SENT_W    = 26;

   typedef struct packed {
      phase_type              phase;
      logic [BIT_POS_W-1:0]   bit_pos;
      logic [SENT_W-1:0]      bits_sent;
   } cursor_type;

endpackage
`default_nettype wire

>>> sv/grsc_ifs.sv
`default_nettype none
interface grsc_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic signed [15:0] coefficient;

   modport source (output valid, output action, output coefficient, input ready);
   modport sink (input valid, input action, input coefficient, output ready);
endinterface

interface grsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [1:0]  status;
   logic        last_byte;
   logic [25:0] total_bits;

   modport source (output valid, output out_byte, output status, output last_byte,
                   output total_bits, input ready);
   modport sink (input valid, input out_byte, input status, input last_byte,
                 input total_bits, output ready);
endinterface
`default_nettype wire

>>> sv/grsc_emit_unit.sv
`default_nettype none
module grsc_emit_unit
   import grsc_pkg::*;
#(
   parameter int CW = 11
) (
   input  wire cursor_type    cur,
   input  wire logic [CW-1:0] index,
   input  wire logic [CW-1:0] count,
   input  wire logic [15:0]   entry,
   input  wire logic [3:0]    low_bits,
   output cursor_type         nxt,
   output logic [CW-1:0]      nxt_index,
   output logic               bit_out,
   output logic               index_moved
);

   logic [15:0]          mag16;
   logic [14:0]          quot;
   logic [CW-1:0]        idx_inc;
   logic [BIT_POS_W-1:0] pos_inc;
   logic                 adv;
   phase_type            next_ph;

   always_comb begin
      mag16   = {1'b0, entry[14:0]};
      quot    = entry[14:0] >> low_bits;
      idx_inc = index + CW'(1);
      pos_inc = cur.bit_pos + BIT_POS_W'(1);
      adv     = 1'b0;
      next_ph = cur.phase;
      bit_out = 1'b0;
      nxt     = cur;
      nxt.bits_sent = cur.bits_sent + SENT_W'(1);
      unique case (cur.phase)
         PH_SIGN: begin
            bit_out = entry[15];
            adv     = 1'b1;
            next_ph = (low_bits != 4'd0) ? PH_LOW : PH_UNARY;
         end
         PH_LOW: begin
            bit_out = (cur.bit_pos < BIT_POS_W'(15)) ? mag16[cur.bit_pos[3:0]] : 1'b0;
            if (pos_inc >= {{(BIT_POS_W-4){1'b0}}, low_bits}) begin
               nxt.bit_pos = '0;
               adv         = 1'b1;
               next_ph     = PH_UNARY;
            end else begin
               nxt.bit_pos = pos_inc;
            end
         end
         PH_UNARY: begin
            if (cur.bit_pos < quot) begin
               bit_out     = 1'b0;
               nxt.bit_pos = pos_inc;
            end else begin
               bit_out     = 1'b1;
               nxt.bit_pos = '0;
               adv         = 1'b1;
               next_ph     = PH_END;
            end
         end
         default: begin
            nxt.bits_sent = cur.bits_sent;
         end
      endcase
      nxt_index   = index;
      index_moved = adv;
      if (adv) begin
         if (idx_inc >= count) begin
            nxt_index = '0;
            nxt.phase = next_ph;
         end else begin
            nxt_index = idx_inc;
         end
      end
   end

endmodule
`default_nettype wire

>>> sv/golomb_rice_signed_compressor.sv
`default_nettype none
// Golomb-Rice compressor for signed coefficients. A load request (action 0) stores one
// coefficient as sign and folded magnitude and answers in the cycle after acceptance with
// status ok, too large, or full. A pull request (action 1) returns the next byte of the
// packed stream (all sign bits, then low_bits binary bits of each magnitude, then each
// high part in unary), LSB first; last_byte and total_bits mark the end, after which the
// next pull starts the stream over. A pull walks the stream one bit per cycle, pausing for
// store reads, through a single bit-extraction unit; the registered read of the
// coefficient store adds a read state at the start of a pull and after each move to
// another coefficient, and the byte is posted, once the output is free, when it is full
// or the stream ends. Refused pulls are answered like loads. The block takes no new
// request while a pull is running. The store needs no initialization after reset.
module golomb_rice_signed_compressor
   import grsc_pkg::*;
#(
   parameter int MAX_COEFFS = 1024
) (
   input  wire logic   clock,
   input  wire logic   reset,
   grsc_req_if.sink    req_ch,
   grsc_rsp_if.source  rsp_ch,
   input  wire logic   csr_we,
   input  wire logic   csr_index,
   input  wire logic [3:0] csr_wdata
);

   localparam int CW = $clog2(MAX_COEFFS + 1);
   localparam int AW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;

   state_type     state_ff, state_in;
   cursor_type    cur_ff, cur_in;
   logic [CW-1:0] index_ff, index_in;
   logic [CW-1:0] count_ff, count_in;
   logic          err_ff, err_in;
   logic [3:0]    low_ff, low_in;
   logic [3:0]    high_ff, high_in;
   logic [2:0]    j_ff, j_in;
   logic [7:0]    byte_ff, byte_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [25:0]   rsp_total_ff, rsp_total_in;

   logic [15:0]   store_mem [MAX_COEFFS];
   logic [15:0]   rd_data_ff;
   logic          store_we;
   logic [15:0]   store_wdata;

   cursor_type    emit_nxt;
   logic [CW-1:0] emit_index;
   logic          emit_bit;
   logic          emit_moved;

   logic          out_free;
   logic          req_fire;
   logic          neg;
   logic [15:0]   mag;
   logic          cur_done;

   grsc_emit_unit #(.CW(CW)) u_emit (
      .cur         (cur_ff),
      .index       (index_ff),
      .count       (count_ff),
      .entry       (rd_data_ff),
      .low_bits    (low_ff),
      .nxt         (emit_nxt),
      .nxt_index   (emit_index),
      .bit_out     (emit_bit),
      .index_moved (emit_moved)
   );

   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE) && out_free;
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_byte   = rsp_byte_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.last_byte  = rsp_last_ff;
   assign rsp_ch.total_bits = rsp_total_ff;

   always_comb begin
      neg         = req_ch.coefficient[15];
      mag         = neg ? ~req_ch.coefficient : req_ch.coefficient;
      store_wdata = {neg, mag[14:0]};
      cur_done    = (emit_nxt.phase == PH_END);

      state_in      = state_ff;
      cur_in        = cur_ff;
      index_in      = index_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      j_in          = j_ff;
      byte_in       = byte_ff;
      store_we      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_total_in  = rsp_total_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_byte_in   = 8'd0;
               rsp_last_in   = 1'b0;
               rsp_total_in  = '0;
               rsp_status_in = ST_OK;
               if (req_ch.action == ACT_LOAD) begin
                  rsp_valid_in = 1'b1;
                  cur_in       = '{phase: PH_SIGN, bit_pos: '0, bits_sent: '0};
                  index_in     = '0;
                  if (count_ff >= CW'(MAX_COEFFS)) begin
                     rsp_status_in = ST_FULL;
                  end else if ((mag >> high_ff) != 16'd0) begin
                     err_in        = 1'b1;
                     rsp_status_in = ST_RANGE;
                  end else begin
                     store_we = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end else if (err_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_RANGE;
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  if (cur_ff.phase == PH_END) begin
                     cur_in   = '{phase: PH_SIGN, bit_pos: '0, bits_sent: '0};
                     index_in = '0;
                  end
                  j_in     = 3'd0;
                  byte_in  = 8'd0;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_BIT;
         end
         S_BIT: begin
            cur_in   = emit_nxt;
            index_in = emit_index;
            byte_in  = byte_ff | (8'(emit_bit) << j_ff);
            j_in     = j_ff + 3'd1;
            if (cur_done || j_ff == 3'd7) begin
               state_in = S_DONE;
            end else if (emit_moved) begin
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = byte_ff;
               rsp_status_in = ST_OK;
               rsp_last_in   = (cur_ff.phase == PH_END);
               rsp_total_in  = (cur_ff.phase == PH_END) ? cur_ff.bits_sent : '0;
               if (cur_ff.phase == PH_END) begin
                  cur_in   = '{phase: PH_SIGN, bit_pos: '0, bits_sent: '0};
                  index_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_BITS:  low_in  = csr_wdata;
            CSR_HIGH_BITS: high_in = csr_wdata;
            default:       low_in  = low_ff;
         endcase
         cur_in   = '{phase: PH_SIGN, bit_pos: '0, bits_sent: '0};
         index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[count_ff[AW-1:0]] <= store_wdata;
      end
      rd_data_ff <= store_mem[index_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '{phase: PH_SIGN, bit_pos: '0, bits_sent: '0};
         index_ff     <= '0;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         low_ff       <= 4'd5;
         high_ff      <= 4'd9;
         j_ff         <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         index_ff     <= index_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_total_ff  <= rsp_total_in;
   end

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_BIT) |-> (index_ff < count_ff))
      else $error("emit index beyond loaded coefficients");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_COEFFS))
      else $error("coefficient count above capacity");

   a_err_pull: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.action == ACT_PULL && err_ff) |=>
         (rsp_valid_ff && rsp_status_ff == ST_RANGE && rsp_byte_ff == 8'd0))
      else $error("pull after range error not refused");

   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_status_ff == ST_OK))
      else $error("final byte with bad status");

endmodule
`default_nettype wire
